// ===== hw/rtl/pwtm_pkg.sv =====
// shared types and constants for the post/wait tag match table
package pwtm_pkg;

  localparam int unsigned NODE_W = 16;
  localparam int unsigned TAG_W  = 4;
  localparam int unsigned CNT_W  = 7;

  localparam logic [TAG_W-1:0] MAX_TAG = 4'd14;

  typedef enum logic [1:0] {
    ACT_INSERT    = 2'd0,
    ACT_WAIT_TAG  = 2'd1,
    ACT_WAIT_NODE = 2'd2,
    ACT_WAIT_ANY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_TAG = 2'd3
  } status_t;

  typedef struct packed {
    action_t            action;
    logic [NODE_W-1:0]  node;
    logic [TAG_W-1:0]   tag;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

endpackage

// ===== hw/rtl/pwtm_ram.sv =====
// generic simple dual-port ram with registered read
module pwtm_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/post_wait_tag_match_table_unit.sv =====
// post/wait tag match table: ordered notice table held in a ram, searched newest first
// insert, wait-any, bad tag and empty-table waits answer the cycle after start;
//   busy stays low, so such requests can follow every cycle
// a node or node+tag wait reads entries newest to oldest and, after a hit, moves each
//   newer entry down one place; the single ram read port paces these steps
// reset clears the count and control; ram contents are not cleared, no clearing pass
module post_wait_tag_match_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned NODE_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  pwtm_pkg::req_t  in_req,
  output logic            busy,
  output logic            out_valid,
  output pwtm_pkg::rsp_t  out_rsp
);

  localparam int unsigned KB = (NODE_BITS < pwtm_pkg::NODE_W) ? NODE_BITS : pwtm_pkg::NODE_W;
  localparam int unsigned EW = KB + pwtm_pkg::TAG_W;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_SHIFT  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  pwtm_pkg::req_t req_r, req_nxt;
  logic           out_valid_r, out_valid_nxt;
  pwtm_pkg::rsp_t out_rsp_r, out_rsp_nxt;
  pwtm_pkg::status_t status_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [EW-1:0]  ram_wdata, ram_rdata;

  logic [CW-1:0]  cnt_m1;
  logic           tbl_empty, tbl_full, in_tag_bad, hit, at_newest;

  pwtm_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1     = cnt_r - CW'(1);
  assign tbl_empty  = (cnt_r == '0);
  assign tbl_full   = (cnt_r == CW'(TABLE_DEPTH));
  assign in_tag_bad = (in_req.tag > pwtm_pkg::MAX_TAG);
  assign at_newest  = (ptr_r == cnt_m1[AW-1:0]);

  // entry layout: node above tag
  assign hit = (ram_rdata[EW-1:pwtm_pkg::TAG_W] == req_r.node[KB-1:0]) &&
               ((req_r.action == pwtm_pkg::ACT_WAIT_NODE) ||
                (ram_rdata[pwtm_pkg::TAG_W-1:0] == req_r.tag));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    status_nxt    = pwtm_pkg::ST_OK;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = {in_req.node[KB-1:0], in_req.tag};
    ram_raddr     = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          unique case (in_req.action)
            pwtm_pkg::ACT_INSERT: begin
              out_valid_nxt = 1'b1;
              if (in_tag_bad) begin
                status_nxt = pwtm_pkg::ST_BAD_TAG;
              end else if (tbl_full) begin
                status_nxt = pwtm_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            pwtm_pkg::ACT_WAIT_TAG,
            pwtm_pkg::ACT_WAIT_NODE: begin
              if ((in_req.action == pwtm_pkg::ACT_WAIT_TAG) && in_tag_bad) begin
                out_valid_nxt = 1'b1;
                status_nxt    = pwtm_pkg::ST_BAD_TAG;
              end else if (tbl_empty) begin
                out_valid_nxt = 1'b1;
                status_nxt    = pwtm_pkg::ST_MISS;
              end else begin
                // start the scan at the newest entry
                ram_raddr = cnt_m1[AW-1:0];
                ptr_nxt   = cnt_m1[AW-1:0];
                state_nxt = S_SEARCH;
              end
            end
            pwtm_pkg::ACT_WAIT_ANY: begin
              out_valid_nxt = 1'b1;
              if (tbl_empty) begin
                status_nxt = pwtm_pkg::ST_MISS;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          if (at_newest) begin
            cnt_nxt       = cnt_m1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ram_raddr = ptr_r + AW'(1);
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (ptr_r == '0) begin
          out_valid_nxt = 1'b1;
          status_nxt    = pwtm_pkg::ST_MISS;
          state_nxt     = S_IDLE;
        end else begin
          ram_raddr = ptr_r - AW'(1);
          ptr_nxt   = ptr_r - AW'(1);
        end
      end
      S_SHIFT: begin
        // move entry at ptr down one place; read and write never touch the same entry
        ram_we    = 1'b1;
        ram_waddr = ptr_r - AW'(1);
        ram_wdata = ram_rdata;
        if (at_newest) begin
          cnt_nxt       = cnt_m1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_rsp_nxt.status      = status_nxt;
    out_rsp_nxt.entry_count = pwtm_pkg::CNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r     <= ptr_nxt;
    req_r     <= req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_quick_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_req.action == pwtm_pkg::ACT_INSERT) ||
                        (in_req.action == pwtm_pkg::ACT_WAIT_ANY))) |=> (out_valid && !busy))
    else $error("insert or wait-any request not answered next cycle");

  a_shift_has_newer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ((ptr_r != '0) && !tbl_empty))
    else $error("compaction step without a lower slot");

  a_reply_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && out_valid_nxt) |=> !busy)
    else $error("request answered but block still busy");

endmodule
